// ===== sv/iad_pkg.sv =====
`timescale 1ns / 1ps
package iad_pkg;
   localparam int MemBytesDef  = 4096;
   localparam int IdxWindowDef = 512;
   localparam int RegCountDef  = 16;
   localparam int ArgsMaxDef   = 3;

   localparam logic [1:0] FUNC_WMEM = 2'd0;
   localparam logic [1:0] FUNC_WREG = 2'd1;
   localparam logic [1:0] FUNC_DEC  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_REG  = 2'd1;
   localparam logic [1:0] KIND_DIR  = 2'd2;
   localparam logic [1:0] KIND_IND  = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] addr;
      logic [31:0] data;
      logic [4:0]  reg_number;
      logic [1:0]  arg_count;
      logic        has_type_byte;
      logic        short_direct;
      logic [1:0]  sole_arg_kind;
      logic [1:0]  skip_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  arg_index;
      logic [1:0]  arg_kind;
      logic [31:0] raw_value;
      logic [31:0] resolved_value;
      logic        bad_register;
      logic [3:0]  instr_length;
      logic        last;
   } rsp_type;

   function automatic logic [2:0] kind_size(input logic [1:0] kind, input logic sd);
      logic [2:0] s;
      case (kind)
         KIND_REG: s = 3'd1;
         KIND_IND: s = 3'd2;
         KIND_DIR: s = sd ? 3'd2 : 3'd4;
         default:  s = 3'd0;
      endcase
      return s;
   endfunction
endpackage

// ===== sv/iad_stream_if.sv =====
`timescale 1ns / 1ps
interface iad_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/iad_front.sv =====
`timescale 1ns / 1ps
module iad_front
   import iad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   output logic    q_valid,
   input  logic    q_ready,
   output req_type q_item
);
   // Two-entry queue; func 3 items are dropped here, arg_count saturates
   // at the configured maximum downstream.
   req_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop, useful;

   assign useful   = in_item.func != FUNC_NONE;
   assign in_ready = cnt_ff != 2'd2;
   assign push     = in_valid && in_ready && useful;
   assign q_valid  = cnt_ff != 2'd0;
   assign q_item   = mem_ff[rp_ff];
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("queue count missed a push");
   a_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !in_ready)
      else $error("full queue still ready");
endmodule

// ===== sv/iad_back.sv =====
`timescale 1ns / 1ps
module iad_back
   import iad_pkg::*;
#(
   parameter int MEM_BYTES  = MemBytesDef,
   parameter int IDX_WINDOW = IdxWindowDef,
   parameter int REG_COUNT  = RegCountDef,
   parameter int ARGS_MAX   = ArgsMaxDef
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_ready,
   input  req_type q_item,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);
   localparam int AW = $clog2(MEM_BYTES);
   localparam int RW = $clog2(REG_COUNT) > 0 ? $clog2(REG_COUNT) : 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_TYPE = 8'b00000010,
      S_ARG  = 8'b00000100,
      S_RES  = 8'b00001000,
      S_IND  = 8'b00010000,
      S_DONE = 8'b00100000,
      S_EMIT = 8'b01000000,
      S_WAIT = 8'b10000000
   } state_type;

   logic [7:0]  arena [MEM_BYTES];
   logic [31:0] regfile_ff [REG_COUNT];
   logic [REG_COUNT-1:0] rvalid_ff;

   state_type   st_ff;
   req_type     it_ff;
   req_type     q_sat;
   logic [7:0]  tb_ff;
   logic [AW-1:0] ra_ff;      // read address
   logic [7:0]  rd_ff;        // registered read data
   logic        rdv_ff;       // read data valid next cycle
   logic        rdv_in;
   logic [AW-1:0] pos_ff;     // next argument byte
   logic [1:0]  ai_ff;        // argument index
   logic [2:0]  bc_ff;        // bytes left in this fetch
   logic [3:0]  len_ff;
   logic [1:0]  kinds_ff [3];
   logic [31:0] raws_ff [3];
   logic [31:0] res_ff [3];
   logic        bad_ff [3];
   logic [31:0] acc_ff;
   logic [1:0]  cnt;
   logic [1:0]  kind;
   logic        out_v_ff;
   logic        emit_go;
   rsp_type     out_ff;
   logic [1:0]  ei_ff;

   assign cnt = (32'(q_item.arg_count) > ARGS_MAX) ? 2'(ARGS_MAX) : q_item.arg_count;
   assign kind = it_ff.has_type_byte ? 2'(tb_ff >> (3'd6 - {ai_ff, 1'b0})) : it_ff.sole_arg_kind;
   assign q_ready   = st_ff == S_IDLE;
   assign out_valid = out_v_ff;
   assign out_item  = out_ff;
   assign emit_go   = st_ff == S_EMIT && (!out_v_ff || out_ready);

   // Incoming item with its argument count saturated.
   always_comb begin
      q_sat = q_item;
      q_sat.arg_count = cnt;
   end

   // Single memory port: registered byte read every cycle.
   always_ff @(posedge clock) begin
      rd_ff <= arena[ra_ff];
      if (st_ff == S_IDLE && q_valid && q_item.func == FUNC_WMEM) begin
         arena[AW'(q_item.addr)] <= q_item.data[7:0];
      end
   end

   logic [31:0] raw_x, rr;
   logic signed [15:0] off;
   logic signed [15:0] rem;
   logic [31:0] rnum;
   always_comb begin
      raw_x = acc_ff;
      if (kind == KIND_IND) raw_x = {{16{acc_ff[15]}}, acc_ff[15:0]};
      off = $signed(raws_ff[ai_ff][15:0]);
      rem = off % 16'(IDX_WINDOW);
      rnum = raws_ff[ai_ff];
      rr = '0;
      if (rnum >= 32'd1 && rnum <= 32'(REG_COUNT) && rvalid_ff[RW'(rnum - 32'd1)])
         rr = regfile_ff[RW'(rnum - 32'd1)];
      // A new read address is issued in these cases; rd_ff then registers its data from ra_ff.
      rdv_in = 1'b0;
      if (st_ff == S_IDLE)
         rdv_in = q_valid && q_item.func == FUNC_DEC && cnt != 2'd0;
      else if (st_ff == S_ARG && !rdv_ff)
         rdv_in = (bc_ff == 3'd0) ? (kind_size(kind, it_ff.short_direct) != 3'd0)
                                  : (bc_ff != 3'd1);
      else if (st_ff == S_DONE)
         rdv_in = ai_ff != it_ff.skip_index && kinds_ff[ai_ff] == KIND_IND;
      else if (st_ff == S_IND && !rdv_ff)
         rdv_in = bc_ff != 3'd1;
   end

   // Sequencer: register writes; for a decode, type byte, argument bytes, resolution per argument, then results.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         rvalid_ff <= '0;
         out_v_ff  <= 1'b0;
         rdv_ff    <= 1'b0;
      end else begin
         out_v_ff <= emit_go || (out_v_ff && !out_ready);
         rdv_ff   <= rdv_in;
         unique case (st_ff)
            S_IDLE: if (q_valid) begin
               it_ff <= q_sat;
               if (q_item.func == FUNC_WREG) begin
                  if (q_item.reg_number >= 5'd1 && 32'(q_item.reg_number) <= REG_COUNT) begin
                     regfile_ff[RW'(q_item.reg_number - 5'd1)] <= q_item.data;
                     rvalid_ff[RW'(q_item.reg_number - 5'd1)] <= 1'b1;
                  end
               end else if (q_item.func == FUNC_DEC && cnt != 2'd0) begin
                  ra_ff  <= AW'(q_item.addr) + AW'(1);
                  pos_ff <= AW'(q_item.addr) + AW'(1) + AW'(q_item.has_type_byte);
                  len_ff <= 4'(q_item.has_type_byte);
                  ai_ff  <= 2'd0;
                  st_ff  <= S_TYPE;
               end
            end
            S_TYPE: if (!rdv_ff) begin
               tb_ff  <= rd_ff;
               bc_ff  <= 3'd0;
               acc_ff <= '0;
               st_ff  <= S_ARG;
            end
            S_ARG: begin
               // Start or continue the fetch of argument ai_ff.
               if (bc_ff == 3'd0 && !rdv_ff) begin
                  bc_ff  <= kind_size(kind, it_ff.short_direct);
                  acc_ff <= '0;
                  if (kind_size(kind, it_ff.short_direct) == 3'd0) st_ff <= S_RES;
                  else ra_ff <= pos_ff;
                  len_ff <= len_ff + 4'(kind_size(kind, it_ff.short_direct));
               end else if (!rdv_ff) begin
                  acc_ff <= {acc_ff[23:0], rd_ff};
                  pos_ff <= pos_ff + AW'(1);
                  bc_ff  <= bc_ff - 3'd1;
                  if (bc_ff == 3'd1) st_ff <= S_RES;
                  else ra_ff <= pos_ff + AW'(1);
               end
            end
            S_RES: begin
               kinds_ff[ai_ff] <= kind;
               raws_ff[ai_ff]  <= raw_x;
               res_ff[ai_ff]   <= raw_x;
               bad_ff[ai_ff]   <= 1'b0;
               st_ff <= S_DONE;
            end
            S_DONE: begin
               if (ai_ff != it_ff.skip_index && kinds_ff[ai_ff] == KIND_REG) begin
                  if (rnum >= 32'd1 && rnum <= 32'(REG_COUNT)) res_ff[ai_ff] <= rr;
                  else begin res_ff[ai_ff] <= '0; bad_ff[ai_ff] <= 1'b1; end
               end
               if (ai_ff != it_ff.skip_index && kinds_ff[ai_ff] == KIND_IND) begin
                  ra_ff  <= AW'(it_ff.addr) + AW'(rem);
                  bc_ff  <= 3'd4;
                  acc_ff <= '0;
                  st_ff  <= S_IND;
               end else if (ai_ff == it_ff.arg_count - 2'd1) begin
                  ei_ff <= 2'd0;
                  st_ff <= S_EMIT;
               end else begin
                  ai_ff <= ai_ff + 2'd1;
                  bc_ff <= 3'd0;
                  st_ff <= S_ARG;
               end
            end
            S_IND: if (!rdv_ff) begin
               acc_ff <= {acc_ff[23:0], rd_ff};
               bc_ff  <= bc_ff - 3'd1;
               if (bc_ff == 3'd1) begin
                  res_ff[ai_ff] <= {acc_ff[23:0], rd_ff};
                  if (ai_ff == it_ff.arg_count - 2'd1) begin
                     ei_ff <= 2'd0;
                     st_ff <= S_EMIT;
                  end else begin
                     ai_ff <= ai_ff + 2'd1;
                     bc_ff <= 3'd0;
                     st_ff <= S_ARG;
                  end
               end else begin
                  ra_ff <= ra_ff + AW'(1);
               end
            end
            S_EMIT: if (emit_go) begin
               out_ff.arg_index      <= ei_ff;
               out_ff.arg_kind       <= kinds_ff[ei_ff];
               out_ff.raw_value      <= raws_ff[ei_ff];
               out_ff.resolved_value <= res_ff[ei_ff];
               out_ff.bad_register   <= bad_ff[ei_ff];
               out_ff.instr_length   <= len_ff;
               out_ff.last           <= ei_ff == it_ff.arg_count - 2'd1;
               ei_ff <= ei_ff + 2'd1;
               if (ei_ff == it_ff.arg_count - 2'd1) st_ff <= S_WAIT;
            end
            S_WAIT: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ready) |=> out_v_ff && $stable(out_ff))
      else $error("result dropped under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> !q_ready)
      else $error("accepting while busy");
   a_index: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> 32'(out_ff.arg_index) < ARGS_MAX)
      else $error("argument index out of range");
endmodule

// ===== sv/instruction_argument_decoder_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         func, addr, data, reg_number, arg_count, flags, kinds
// rsp      out        one argument result per transfer
// A write is done in the idle state and leaves the back end ready. A decode steps through
// the type byte, each argument's bytes and each indirect word, all through the one byte-wide
// arena read port, then each result; the back end takes no new item until its last result is issued.
// Reset is synchronous and invalidates the register file, which then reads as zero; the arena is undefined until
// written. A stalled rsp holds the back end; the two-entry queue keeps taking req
// transfers until it is full.
module instruction_argument_decoder_unit
   import iad_pkg::*;
#(
   parameter int MEM_BYTES  = MemBytesDef,
   parameter int IDX_WINDOW = IdxWindowDef,
   parameter int REG_COUNT  = RegCountDef,
   parameter int ARGS_MAX   = ArgsMaxDef
) (
   input logic clock,
   input logic reset,
   iad_stream_if.sink   req,
   iad_stream_if.source rsp
);
   logic    q_valid, q_ready;
   req_type q_item;

   iad_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_item(req.payload),
      .q_valid, .q_ready, .q_item
   );

   iad_back #(
      .MEM_BYTES(MEM_BYTES), .IDX_WINDOW(IDX_WINDOW),
      .REG_COUNT(REG_COUNT), .ARGS_MAX(ARGS_MAX)
   ) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_item(rsp.payload)
   );
endmodule

// ===== test/instruction_argument_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
module instruction_argument_decoder_unit_tb;
   import iad_pkg::*;

   localparam logic [1:0] ResolveAll = 2'd3;

   // Holds an image of the arena and register file and the queue of argument results due.
   class arg_decode_scoreboard;
      logic [7:0]  arena_img [MemBytesDef];
      bit          written [MemBytesDef];
      logic [31:0] reg_img [RegCountDef];
      rsp_type     due_q [$];
      int          errors;

      function new();
         foreach (arena_img[i]) arena_img[i] = '0;
         foreach (written[i]) written[i] = 1'b0;
         foreach (reg_img[i]) reg_img[i] = '0;
         errors = 0;
      endfunction

      function int wrap(int a);
         int m;
         m = a % MemBytesDef;
         if (m < 0) m += MemBytesDef;
         return m;
      endfunction

      // Big-endian fetch with wraparound.
      function logic [31:0] fetch(int start, int n);
         logic [31:0] v;
         v = '0;
         for (int i = 0; i < n; i++) v = {v[23:0], arena_img[wrap(start + i)]};
         return v;
      endfunction

      function int arg_bytes(logic [1:0] kind, logic sd);
         case (kind)
            KIND_REG: return 1;
            KIND_IND: return 2;
            KIND_DIR: return sd ? 2 : 4;
            default:  return 0;
         endcase
      endfunction

      // Returns the first never-written arena byte that a decode would read, or -1.
      function int missing(req_type r);
         int          base, offs, n, cnt, rem, a;
         logic [7:0]  tbyte;
         logic [1:0]  kind;
         logic [31:0] raw;
         logic [15:0] low16;
         if (r.func != FUNC_DEC) return -1;
         cnt = (r.arg_count > ArgsMaxDef) ? ArgsMaxDef : r.arg_count;
         if (cnt == 0) return -1;
         base = wrap(r.addr + 1);
         if (!written[base]) return base;
         tbyte = arena_img[base];
         offs = int'(r.has_type_byte);
         for (int i = 0; i < cnt; i++) begin
            kind = r.has_type_byte ? tbyte[7 - 2 * i -: 2] : r.sole_arg_kind;
            n = arg_bytes(kind, r.short_direct);
            for (int j = 0; j < n; j++) begin
               a = wrap(base + offs + j);
               if (!written[a]) return a;
            end
            raw = fetch(base + offs, n);
            offs += n;
            if (i != r.skip_index && kind == KIND_IND) begin
               low16 = raw[15:0];
               rem = $signed(low16) % IdxWindowDef;
               for (int j = 0; j < 4; j++) begin
                  a = wrap(r.addr + rem + j);
                  if (!written[a]) return a;
               end
            end
         end
         return -1;
      endfunction

      // Updates the image for writes and computes the argument results of a decode.
      function void note(req_type r);
         int          base, offs, n, cnt, rem;
         logic [7:0]  tbyte;
         logic [1:0]  kinds [3];
         logic [31:0] raws [3], res [3];
         logic        bad [3];
         logic [15:0] low16;
         rsp_type     e;
         case (r.func)
            FUNC_WMEM: begin
               arena_img[r.addr] = r.data[7:0];
               written[r.addr] = 1'b1;
            end
            FUNC_WREG: if (r.reg_number >= 1 && r.reg_number <= RegCountDef)
               reg_img[4'(r.reg_number - 5'd1)] = r.data;
            FUNC_DEC: begin
               cnt = (r.arg_count > ArgsMaxDef) ? ArgsMaxDef : r.arg_count;
               base = wrap(r.addr + 1);
               tbyte = arena_img[base];
               offs = int'(r.has_type_byte);
               for (int i = 0; i < cnt; i++) begin
                  kinds[i] = r.has_type_byte ? tbyte[7 - 2 * i -: 2] : r.sole_arg_kind;
                  n = arg_bytes(kinds[i], r.short_direct);
                  raws[i] = fetch(base + offs, n);
                  if (kinds[i] == KIND_IND && raws[i][15]) raws[i][31:16] = 16'hFFFF;
                  offs += n;
                  res[i] = raws[i];
                  bad[i] = 1'b0;
                  if (i != r.skip_index) begin
                     if (kinds[i] == KIND_REG) begin
                        if (raws[i] >= 1 && raws[i] <= RegCountDef) begin
                           res[i] = reg_img[4'(raws[i] - 32'd1)];
                        end else begin
                           res[i] = '0;
                           bad[i] = 1'b1;
                        end
                     end else if (kinds[i] == KIND_IND) begin
                        low16 = raws[i][15:0];
                        rem = $signed(low16) % IdxWindowDef;
                        res[i] = fetch(wrap(r.addr + rem), 4);
                     end
                  end
               end
               for (int i = 0; i < cnt; i++) begin
                  e.arg_index = 2'(i);
                  e.arg_kind = kinds[i];
                  e.raw_value = raws[i];
                  e.resolved_value = res[i];
                  e.bad_register = bad[i];
                  e.instr_length = 4'(offs);
                  e.last = (i == cnt - 1);
                  due_q.push_back(e);
               end
            end
            default: ;
         endcase
      endfunction

      function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compares one result transfer with the oldest pending argument result.
      function void check(rsp_type a);
         rsp_type e;
         if (due_q.size() == 0) begin
            $error("unexpected result transfer %p", a);
            errors++;
            return;
         end
         e = due_q.pop_front();
         cmp("arg_index", 32'(e.arg_index), 32'(a.arg_index));
         cmp("arg_kind", 32'(e.arg_kind), 32'(a.arg_kind));
         cmp("raw_value", e.raw_value, a.raw_value);
         cmp("resolved_value", e.resolved_value, a.resolved_value);
         cmp("bad_register", 32'(e.bad_register), 32'(a.bad_register));
         cmp("instr_length", 32'(e.instr_length), 32'(a.instr_length));
         cmp("last", 32'(e.last), 32'(a.last));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   sent = 0;

   iad_stream_if #(.payload_type(req_type)) req_if ();
   iad_stream_if #(.payload_type(rsp_type)) rsp_if ();

   arg_decode_scoreboard sb = new();

   instruction_argument_decoder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check(rsp_if.payload);
   end

   initial begin
      #20_000_000;
      $display("instruction_argument_decoder_unit_tb: done, errors");
      $finish;
   end

   function req_type noise_req();
      logic [63:0] w;
      req_type     r;
      w = {$urandom, $urandom};
      r = w[$bits(req_type)-1:0];
      return r;
   endfunction

   // Drives one item, with an optional idle gap first, and waits for its transfer.
   task automatic send(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_if.payload <= r;
      req_if.valid <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      sb.note(r);
      sent++;
   endtask

   task automatic put_byte(int a, int v);
      req_type r;
      r = noise_req();
      r.func = FUNC_WMEM;
      r.addr = 12'(a);
      r.data[7:0] = 8'(v);
      send(r);
   endtask

   // Writes random bytes wherever the decode would otherwise read a never-written byte.
   task automatic prepare(req_type r);
      int a;
      a = sb.missing(r);
      while (a >= 0) begin
         put_byte(a, $urandom);
         a = sb.missing(r);
      end
   endtask

   task automatic put_reg(int n, logic [31:0] v);
      req_type r;
      r = noise_req();
      r.func = FUNC_WREG;
      r.reg_number = 5'(n);
      r.data = v;
      send(r);
   endtask

   task automatic decode(int pc, int cnt, logic tb, logic sd, logic [1:0] sole,
                         logic [1:0] skip);
      req_type r;
      r = noise_req();
      r.func = FUNC_DEC;
      r.addr = 12'(pc);
      r.arg_count = 2'(cnt);
      r.has_type_byte = tb;
      r.short_direct = sd;
      r.sole_arg_kind = sole;
      r.skip_index = skip;
      prepare(r);
      send(r);
   endtask

   // Lets the block run dry before the sender resumes.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Usually has a type byte; about half the following bytes are drawn from 0 to RegCountDef + 1.
   task automatic crafted_decode();
      int pc;
      pc = $urandom_range(4095);
      put_byte(pc + 1, $urandom);
      for (int i = 2; i < 15; i++)
         put_byte((pc + i) % MemBytesDef,
                  $urandom_range(1) ? $urandom_range(RegCountDef + 1) : $urandom_range(255));
      decode(pc, $urandom_range(1, 3), $urandom_range(9) != 0, 1'($urandom),
             2'($urandom), 2'($urandom));
   endtask

   task automatic random_phase(int target);
      int stop, pick;
      req_type r;
      stop = sent + target;
      while (sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            crafted_decode();
         end else if (pick < 60) begin
            r = noise_req();
            r.func = FUNC_DEC;
            prepare(r);
            send(r);
         end else if (pick < 80) begin
            r = noise_req();
            r.func = FUNC_WMEM;
            send(r);
         end else if (pick < 95) begin
            r = noise_req();
            r.func = FUNC_WREG;
            send(r);
         end else begin
            r = noise_req();
            r.func = FUNC_NONE;
            send(r);
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register extremes and ignored register numbers.
      put_reg(16, 32'h8000_0000);
      put_reg(1, 32'h7FFF_FFFF);
      put_reg(0, 32'hDEAD_BEEF);
      put_reg(31, 32'hFFFF_FFFF);

      // Type byte register, direct, indirect, with the arguments wrapping past the end.
      put_byte(4095, 8'h6C);
      put_byte(0, 8'h10);
      put_byte(5, 8'h80);
      put_byte(6, 8'h00);
      decode(4094, 3, 1'b1, 1'b0, KIND_NONE, ResolveAll);
      decode(4094, 3, 1'b1, 1'b1, KIND_NONE, 2'd0);

      // No type byte, register kind: register zero, out of range, and valid.
      put_byte(101, 8'h00);
      put_byte(102, 8'h11);
      put_byte(103, 8'h01);
      decode(100, 3, 1'b0, 1'b0, KIND_REG, ResolveAll);
      decode(100, 3, 1'b0, 1'b0, KIND_REG, 2'd1);
      decode(200, 2, 1'b0, 1'b0, KIND_NONE, ResolveAll);

      // Indirect offsets at the positive extreme and wrapping past the arena end, then a direct decode.
      put_byte(301, 8'h7F);
      put_byte(302, 8'hFF);
      decode(300, 1, 1'b0, 1'b0, KIND_IND, ResolveAll);
      decode(4094, 1, 1'b0, 1'b1, KIND_IND, ResolveAll);
      decode(400, 2, 1'b0, 1'b0, KIND_DIR, 2'd1);

      // Zero arguments and the unused function code give no results.
      decode(500, 0, 1'b1, 1'b0, KIND_REG, ResolveAll);
      begin
         req_type r;
         r = noise_req();
         r.func = FUNC_NONE;
         send(r);
      end
      drain();

      // Random traffic under several idle and stall patterns.
      random_phase(65);
      send_idle_pct = 87;
      random_phase(65);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 87;
      random_phase(65);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      random_phase(65);

      drain();
      if (sb.errors == 0) begin
         $display("instruction_argument_decoder_unit_tb: done, clean");
      end else begin
         $display("instruction_argument_decoder_unit_tb: done, errors");
      end
      $finish;
   end
endmodule

// ===== instruction_argument_decoder_unit.f =====
sv/iad_pkg.sv
sv/iad_stream_if.sv
sv/iad_front.sv
sv/iad_back.sv
sv/instruction_argument_decoder_unit.sv
test/instruction_argument_decoder_unit_tb.sv
